### rtl/srxf_pkg.sv
// ----------------------------------------------------------------------------
// srxf_pkg: shared definitions for the serial receive FIFO
// Buffer geometry, flow-control bytes, function codes, register indexes and
// the command bundle that the controller drives into the datapath.
// ----------------------------------------------------------------------------
package srxf_pkg;

  // Receive buffer geometry.
  localparam int DEPTH = 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field and register widths.
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int THR_W   = 13;
  localparam int FILL_W  = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;

  // Software flow-control bytes.
  localparam logic [BYTE_W-1:0] XON_BYTE  = 8'h11;
  localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;

  // Function codes of an input item.
  localparam logic [FUNC_W-1:0] FUNC_LINE_RX = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TX      = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_THR  = 2'd1;
  localparam logic [THR_W-1:0] XOFF_THR_RESET = 13'd300;
  localparam logic [THR_W-1:0] XON_THR_RESET  = 13'd500;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // apply the item to the buffer state
  } srxf_cmd_t;

  // Ring pointer advance with wrap at the end of the buffer.
  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

### rtl/srxf_ctrl.sv
// ----------------------------------------------------------------------------
// srxf_ctrl: item sequencer
// Accepts one item at a time, waits in the read state for the buffer read,
// issues the execute command and raises the result strobe in the next cycle.
// ----------------------------------------------------------------------------
module srxf_ctrl
  import srxf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output srxf_cmd_t cmd,
  output logic      out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  // Commands and status.
  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;

endmodule

### rtl/srxf_datapath.sv
// ----------------------------------------------------------------------------
// srxf_datapath: buffer, pointers and flow-control state
// Holds the receive ring, its pointers and count, the XON/XOFF hold flags,
// the threshold registers and the registered result fields.
// ----------------------------------------------------------------------------
module srxf_datapath
  import srxf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  srxf_cmd_t            cmd,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output logic                 out_line_tx_valid,
  output logic [BYTE_W-1:0]    out_line_tx_byte,
  output logic                 out_read_valid,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_tx_rejected,
  output logic                 out_char_dropped,
  output logic                 out_output_blocked,
  output logic                 out_input_blocked,
  output logic [FILL_W-1:0]    out_fill_level
);

  // Receive ring.
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Item and state registers.
  logic [FUNC_W-1:0] func_r;
  logic [BYTE_W-1:0] byte_r;
  logic [AW-1:0]     write_pos_r, write_pos_nxt;
  logic [AW-1:0]     read_pos_r, read_pos_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              out_hold_r, out_hold_nxt;
  logic              in_hold_r, in_hold_nxt;
  logic [THR_W-1:0]  xoff_thr_r, xon_thr_r;

  // Result registers.
  logic              tx_v_r, tx_v_nxt;
  logic [BYTE_W-1:0] tx_b_r, tx_b_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [BYTE_W-1:0] rd_b_r, rd_b_nxt;
  logic              rej_r, rej_nxt;
  logic              drop_r, drop_nxt;

  logic              mem_we;
  logic [CMP_W-1:0]  free_after, free_before;
  logic              is_flow_byte;

  assign is_flow_byte = (byte_r == XON_BYTE) || (byte_r == XOFF_BYTE);
  assign free_before  = CMP_W'(DEPTH) - CMP_W'(held_r);
  assign free_after   = CMP_W'(DEPTH) - CMP_W'(held_nxt);

  // Item execution.
  always_comb begin
    write_pos_nxt = write_pos_r;
    read_pos_nxt  = read_pos_r;
    held_nxt      = held_r;
    out_hold_nxt  = out_hold_r;
    in_hold_nxt   = in_hold_r;
    tx_v_nxt      = 1'b0;
    tx_b_nxt      = '0;
    rd_v_nxt      = 1'b0;
    rd_b_nxt      = '0;
    rej_nxt       = 1'b0;
    drop_nxt      = 1'b0;
    mem_we        = 1'b0;
    case (func_r)
      FUNC_LINE_RX: begin
        if (byte_r == XOFF_BYTE) begin
          out_hold_nxt = 1'b1;
        end else if (byte_r == XON_BYTE) begin
          out_hold_nxt = 1'b0;
        end else if (held_r < CNT_W'(DEPTH)) begin
          mem_we        = cmd.exec;
          write_pos_nxt = next_pos(write_pos_r);
          held_nxt      = held_r + 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
        // Ask the partner to pause when free space runs low.
        if (!in_hold_r && (free_after < CMP_W'(xoff_thr_r))) begin
          tx_v_nxt    = 1'b1;
          tx_b_nxt    = XOFF_BYTE;
          in_hold_nxt = 1'b1;
        end
      end
      FUNC_READ: begin
        // Release the partner before popping once space has recovered.
        if (in_hold_r && (free_before > CMP_W'(xon_thr_r))) begin
          tx_v_nxt    = 1'b1;
          tx_b_nxt    = XON_BYTE;
          in_hold_nxt = 1'b0;
        end
        if (held_r != '0) begin
          rd_v_nxt     = 1'b1;
          rd_b_nxt     = rd_data_r;
          read_pos_nxt = next_pos(read_pos_r);
          held_nxt     = held_r - 1'b1;
        end
      end
      FUNC_TX: begin
        if (is_flow_byte || !out_hold_r) begin
          tx_v_nxt = 1'b1;
          tx_b_nxt = byte_r;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Ring write and registered read at the current read pointer.
  always_ff @(posedge clk) begin
    if (mem_we) mem[write_pos_r] <= byte_r;
    rd_data_r <= mem[read_pos_r];
  end

  // Item capture and result fields.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      byte_r <= in_data_byte;
    end
    if (cmd.exec) begin
      tx_v_r <= tx_v_nxt;
      tx_b_r <= tx_b_nxt;
      rd_v_r <= rd_v_nxt;
      rd_b_r <= rd_b_nxt;
      rej_r  <= rej_nxt;
      drop_r <= drop_nxt;
    end
  end

  // Buffer state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      read_pos_r  <= '0;
      held_r      <= '0;
      out_hold_r  <= 1'b0;
      in_hold_r   <= 1'b0;
      xoff_thr_r  <= XOFF_THR_RESET;
      xon_thr_r   <= XON_THR_RESET;
    end else begin
      if (cmd.exec) begin
        write_pos_r <= write_pos_nxt;
        read_pos_r  <= read_pos_nxt;
        held_r      <= held_nxt;
        out_hold_r  <= out_hold_nxt;
        in_hold_r   <= in_hold_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_XOFF_THR: xoff_thr_r <= cfg_data;
          CFG_XON_THR:  xon_thr_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_line_tx_valid  = tx_v_r;
  assign out_line_tx_byte   = tx_b_r;
  assign out_read_valid     = rd_v_r;
  assign out_read_byte      = rd_b_r;
  assign out_tx_rejected    = rej_r;
  assign out_char_dropped   = drop_r;
  assign out_output_blocked = out_hold_r;
  assign out_input_blocked  = in_hold_r;
  assign out_fill_level     = FILL_W'(held_r);

endmodule

### rtl/serial_rx_fifo_xon_xoff.sv
// ----------------------------------------------------------------------------
// serial_rx_fifo_xon_xoff: serial receive FIFO with XON/XOFF flow control
// Buffers received line bytes for the host and handles software flow control.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_func, in_data_byte) is taken at a clock edge where start is
//   high and busy is low. in_func selects a received line byte, a host read
//   or a host transmit; codes outside these three only report status.
//   Each item gives exactly one result beat: all out_ fields are valid for
//   the single cycle in which out_valid is high. The receiver cannot stall,
//   so it must take the beat in that cycle.
//   After the accepting edge the item passes the registered read of the
//   buffer memory, the execute state and the result register; a new item
//   is taken only when busy is low again.
//   Configuration: a beat on cfg_valid/cfg_ready writes the threshold at
//   cfg_index; cfg_ready is always high. Write only while busy is low.
//   Reset (rst_n low, synchronous) empties the buffer, clears both hold
//   flags and restores the thresholds to 300 and 500. No clearing pass is
//   needed: buffer entries are read only after they have been written.
// ----------------------------------------------------------------------------
module serial_rx_fifo_xon_xoff
  import srxf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic                 out_valid,
  output logic                 out_line_tx_valid,
  output logic [BYTE_W-1:0]    out_line_tx_byte,
  output logic                 out_read_valid,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_tx_rejected,
  output logic                 out_char_dropped,
  output logic                 out_output_blocked,
  output logic                 out_input_blocked,
  output logic [FILL_W-1:0]    out_fill_level,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  srxf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequencer.
  srxf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Buffer and flow-control datapath.
  srxf_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_line_tx_valid  (out_line_tx_valid),
    .out_line_tx_byte   (out_line_tx_byte),
    .out_read_valid     (out_read_valid),
    .out_read_byte      (out_read_byte),
    .out_tx_rejected    (out_tx_rejected),
    .out_char_dropped   (out_char_dropped),
    .out_output_blocked (out_output_blocked),
    .out_input_blocked  (out_input_blocked),
    .out_fill_level     (out_fill_level)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // A result beat only follows a busy cycle.
  a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  // The fill level never exceeds the buffer size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_fill_level <= FILL_W'(DEPTH))
    else $error("fill level above buffer depth");

  // A byte is dropped only while the buffer is full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_dropped) |-> (out_fill_level == FILL_W'(DEPTH)))
    else $error("byte dropped with space left in the buffer");
`endif

endmodule
